>>> sv/bia_pkg.sv
// shared constants, status codes and the address-width helper of the bitmap id allocator
`default_nettype none

package bia_pkg;

	// fixed field widths
	localparam int ID_W     = 13;
	localparam int STATUS_W = 2;

	// default geometry of the id space
	localparam int MIN_ID_DEF    = 300;
	localparam int MAX_ID_DEF    = 5000;
	localparam int WORD_BITS_DEF = 32;
	localparam int NUM_WORDS_DEF = 147;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	// address width for a memory of the given depth, never below one bit
	function automatic int addr_w(input int depth);
		int w;
		w = (depth > 1) ? $clog2(depth) : 1;
		return w;
	endfunction

endpackage

`default_nettype wire

>>> sv/bia_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module bia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 147
) (
	input  wire logic                                clk,
	input  wire logic                                we,
	input  wire logic [bia_pkg::addr_w(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]                    wdata,
	input  wire logic                                re,
	input  wire logic [bia_pkg::addr_w(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]                    rdata
);
	import bia_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/bitmap_id_allocator.sv
// top level of the bitmap id allocator: command port, sequencer and bitmap ram
// allocate: scans from word 0 up to the first non-full word, then sets its lowest free bit;
//   the ram scan reads one word per cycle while each word read back is full
// release: reciprocal divide, remainder fix-up, read-modify-write; an out-of-range
//   release reports in the next cycle; one command at a time, busy high meanwhile
// reset: arst_n clears the sequencer and the per-word valid bits, so the whole map reads
//   as free right after reset with no clearing pass; the receiver cannot stall a result
`default_nettype none

module bitmap_id_allocator #(
	parameter int MIN_ID    = bia_pkg::MIN_ID_DEF,
	parameter int MAX_ID    = bia_pkg::MAX_ID_DEF,
	parameter int WORD_BITS = bia_pkg::WORD_BITS_DEF,
	parameter int NUM_WORDS = bia_pkg::NUM_WORDS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          mode,
	input  wire logic [bia_pkg::ID_W-1:0]      release_id,
	output logic                               done,
	output logic      [bia_pkg::ID_W-1:0]      granted_id,
	output logic      [bia_pkg::STATUS_W-1:0]  status
);
	import bia_pkg::*;

	// geometry
	localparam int ADDR_W  = addr_w(NUM_WORDS);
	localparam int CNT_W   = $clog2(NUM_WORDS + 1);
	localparam int BIT_W   = $clog2(WORD_BITS);
	localparam int SUM_RAW = $clog2(MIN_ID + NUM_WORDS * WORD_BITS + 1);
	localparam int SUM_W   = (SUM_RAW > ID_W) ? SUM_RAW : ID_W;
	localparam int REM_W   = $clog2(2 * WORD_BITS);

	// release offset / WORD_BITS by reciprocal: estimate is the quotient or one below
	localparam int RCP_SH  = ID_W + 1;
	localparam int RECIP   = (2 ** RCP_SH) / WORD_BITS;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int MUL_W   = ID_W + RECIP_W;

	localparam logic [ID_W-1:0]  MIN_ID_V = ID_W'(MIN_ID);
	localparam logic [ID_W-1:0]  MAX_ID_V = ID_W'(MAX_ID);
	localparam logic [ID_W-1:0]  WB_ID    = ID_W'(WORD_BITS);
	localparam logic [ID_W-1:0]  NW_ID    = ID_W'(NUM_WORDS);
	localparam logic [REM_W-1:0] WB_REM   = REM_W'(WORD_BITS);
	localparam logic [CNT_W-1:0] NW_CNT   = CNT_W'(NUM_WORDS);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_SCAN    = 8'b0000_0010,
		ST_PICK    = 8'b0000_0100,
		ST_COMMIT  = 8'b0000_1000,
		ST_REL_MUL = 8'b0001_0000,
		ST_REL_REM = 8'b0010_0000,
		ST_REL_CHK = 8'b0100_0000,
		ST_REL_WR  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// ram interface
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	// read stage: address and valid bit travel with the registered read data
	logic [ADDR_W-1:0]    addr_s1;
	logic                 vld_s1;
	logic [WORD_BITS-1:0] rd_word;

	// one valid bit per word: a word never written reads as all free
	logic [NUM_WORDS-1:0] valid_q;

	// sequencer registers
	logic [CNT_W-1:0]     iss_q;    // next word address to issue during the scan
	logic [WORD_BITS-1:0] word_q;   // first non-full word
	logic [ADDR_W-1:0]    widx_q;   // its address (or the release word)
	logic [WORD_BITS-1:0] ohot_q;   // lowest free bit, one-hot
	logic [BIT_W-1:0]     bit_q;    // its position (or the release bit)
	logic [SUM_W-1:0]     base_q;   // MIN_ID + widx * WORD_BITS
	logic [ID_W-1:0]      off_q;    // release offset from MIN_ID
	logic [ID_W-1:0]      quo_q;    // estimated word index of the release
	logic [REM_W-1:0]     rem_q;    // remainder against the estimate

	// combinational helpers
	logic [WORD_BITS-1:0] low_zero;
	logic [BIT_W-1:0]     low_pos;
	logic [SUM_W-1:0]     cand_id;
	logic [MUL_W-1:0]     quo_prod;
	logic [ID_W-1:0]      quo_back;
	logic [ID_W-1:0]      rel_word;
	logic [REM_W-1:0]     rel_bit;

	logic                  accept;
	logic                  rel_bad;

	bia_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NUM_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign rel_bad = (release_id < MIN_ID_V) || (release_id > MAX_ID_V);
	assign rd_word = vld_s1 ? ram_rdata : '0;

	// lowest clear bit of the found word, isolated with one add
	assign low_zero = ~word_q & (word_q + WORD_BITS'(1));

	// one-hot to index: each output bit is an or over the matching positions
	always_comb begin
		low_pos = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			low_pos = low_pos | (low_zero[i] ? BIT_W'(i) : '0);
		end
	end

	assign cand_id  = base_q + SUM_W'(bit_q);
	assign quo_prod = MUL_W'(off_q) * MUL_W'(RECIP);
	assign quo_back = ID_W'(quo_q * WB_ID);

	// remainder fix-up when the quotient estimate came out one low
	always_comb begin
		if (rem_q >= WB_REM) begin
			rel_word = quo_q + ID_W'(1);
			rel_bit  = rem_q - WB_REM;
		end else begin
			rel_word = quo_q;
			rel_bit  = rem_q;
		end
	end

	// ram read port: word 0 on an accepted allocate, then one word a cycle while the words read back
	// are full, or the release word once its index is known
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				ram_re = accept && !mode;
			end
			ST_SCAN: begin
				ram_re    = (&rd_word) && (iss_q != NW_CNT);
				ram_raddr = iss_q[ADDR_W-1:0];
			end
			ST_REL_CHK: begin
				ram_re    = (rel_word < NW_ID);
				ram_raddr = rel_word[ADDR_W-1:0];
			end
			ST_PICK, ST_COMMIT, ST_REL_MUL, ST_REL_REM, ST_REL_WR: begin
				ram_re = 1'b0;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// ram write port: set the granted bit, or clear the released one
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = widx_q;
		ram_wdata = word_q | ohot_q;
		if (state_q == ST_COMMIT) begin
			ram_we = (cand_id <= SUM_W'(MAX_ID));
		end else if (state_q == ST_REL_WR) begin
			ram_we    = 1'b1;
			ram_wdata = rd_word & ~(WORD_BITS'(1) << bit_q);
		end
	end

	// read stage tags
	always_ff @(posedge clk) begin
		if (ram_re) begin
			addr_s1 <= ram_raddr;
			vld_s1  <= valid_q[ram_raddr];
		end
	end

	// valid bits, cleared at once by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !mode) begin
						state_q <= ST_SCAN;
					end else if (accept && rel_bad) begin
						// out-of-range release answers at once
						done <= 1'b1;
					end else if (accept) begin
						state_q <= ST_REL_MUL;
					end
				end
				ST_SCAN: begin
					if (!(&rd_word)) begin
						state_q <= ST_PICK;
					end else if (iss_q == NW_CNT) begin
						// every word full
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_PICK: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_REL_MUL: begin
					state_q <= ST_REL_REM;
				end
				ST_REL_REM: begin
					state_q <= ST_REL_CHK;
				end
				ST_REL_CHK: begin
					if (rel_word < NW_ID) begin
						state_q <= ST_REL_WR;
					end else begin
						// id maps past the last word
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_REL_WR: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				iss_q      <= CNT_W'(1);
				off_q      <= release_id - MIN_ID_V;
				granted_id <= '0;
				status     <= STATUS_RANGE;
			end
			ST_SCAN: begin
				word_q <= rd_word;
				widx_q <= addr_s1;
				if (ram_re) begin
					iss_q <= iss_q + CNT_W'(1);
				end
				granted_id <= '0;
				status     <= STATUS_NONE;
			end
			ST_PICK: begin
				ohot_q <= low_zero;
				bit_q  <= low_pos;
				base_q <= SUM_W'(widx_q) * SUM_W'(WORD_BITS) + SUM_W'(MIN_ID);
			end
			ST_COMMIT: begin
				if (cand_id <= SUM_W'(MAX_ID)) begin
					granted_id <= ID_W'(cand_id);
					status     <= STATUS_OK;
				end else begin
					granted_id <= '0;
					status     <= STATUS_NONE;
				end
			end
			ST_REL_MUL: begin
				quo_q <= ID_W'(quo_prod >> RCP_SH);
			end
			ST_REL_REM: begin
				rem_q <= REM_W'(off_q - quo_back);
			end
			ST_REL_CHK: begin
				widx_q     <= rel_word[ADDR_W-1:0];
				bit_q      <= rel_bit[BIT_W-1:0];
				granted_id <= '0;
				status     <= STATUS_RANGE;
			end
			ST_REL_WR: begin
				granted_id <= '0;
				status     <= STATUS_OK;
			end
			default: begin
				status <= STATUS_OK;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> sv/bia_checker.sv
// port-level checker for the bitmap id allocator, bound to the top level
`default_nettype none

module bia_checker #(
	parameter int MIN_ID = bia_pkg::MIN_ID_DEF,
	parameter int MAX_ID = bia_pkg::MAX_ID_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          mode,
	input wire logic [bia_pkg::ID_W-1:0]      release_id,
	input wire logic                          done,
	input wire logic [bia_pkg::ID_W-1:0]      granted_id,
	input wire logic [bia_pkg::STATUS_W-1:0]  status
);
	import bia_pkg::*;

	localparam logic [ID_W-1:0] MIN_ID_V = ID_W'(MIN_ID);
	localparam logic [ID_W-1:0] MAX_ID_V = ID_W'(MAX_ID);

	// a failed command never carries an id
	a_fail_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != STATUS_OK) |-> granted_id == '0)
		else $error("failed result carries an id");

	// a granted id lies inside the id range
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_OK) && (granted_id != '0)
			|-> (granted_id >= MIN_ID_V) && (granted_id <= MAX_ID_V))
		else $error("granted id outside the id range");

	// an accepted allocate is followed by busy and no result yet, as the map scan begins
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !mode |=> busy && !done)
		else $error("allocate beat not held busy");

	// a release below or above the id range reports at once
	a_rel_range: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode && ((release_id < MIN_ID_V) || (release_id > MAX_ID_V))
			|=> done && (status == STATUS_RANGE) && !busy)
		else $error("out-of-range release not flagged");

endmodule

bind bitmap_id_allocator bia_checker #(
	.MIN_ID (MIN_ID),
	.MAX_ID (MAX_ID)
) u_bia_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.mode       (mode),
	.release_id (release_id),
	.done       (done),
	.granted_id (granted_id),
	.status     (status)
);

`default_nettype wire
